### hdl/amfi_pkg.sv
// Package for the approximate memory fault injector: types, constants, functions.
package amfi_pkg;

  localparam int unsigned TableDepthDefault = 4096;
  localparam logic [63:0] SeedValue = 64'd12345;
  localparam logic [63:0] MildReset = 64'd18446744073710;
  localparam logic [63:0] MediumReset = 64'd1844674407370955;
  localparam logic [63:0] AggressiveReset = 64'd184467440737095516;
  localparam logic [63:0] TestReset = 64'd184467440737;

  // request codes
  localparam logic [1:0] ReqStore = 2'd0;
  localparam logic [1:0] ReqLoad = 2'd1;
  localparam logic [1:0] ReqArith = 2'd2;
  localparam logic [1:0] ReqNone = 2'd3;

  // arithmetic modes
  localparam logic [2:0] ModeMild = 3'd1;
  localparam logic [2:0] ModeMedium = 3'd2;
  localparam logic [2:0] ModeAggressive = 3'd3;
  localparam logic [2:0] ModeTest = 3'd4;

  // configuration register indexes
  localparam logic [2:0] RegDecay = 3'd0;
  localparam logic [2:0] RegMild = 3'd1;
  localparam logic [2:0] RegMedium = 3'd2;
  localparam logic [2:0] RegAggressive = 3'd3;
  localparam logic [2:0] RegTest = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] address;
    logic [63:0] data_value;
    logic [15:0] alignment;
    logic [63:0] timestamp;
    logic [3:0]  size_bytes;
    logic [2:0]  error_mode;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        align_error;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_DISPATCH, ST_READ, ST_MUL0, ST_MUL1, ST_MUL2, ST_DRAW,
    ST_WRITE, ST_ARITH, ST_ARITH2, ST_DONE
  } state_t;

  // one xorshift64 step
  function automatic logic [63:0] xs_step(input logic [63:0] x);
    logic [63:0] a;
    logic [63:0] b;
    a = x ^ (x >> 21);
    b = a ^ (a << 35);
    return b ^ (b >> 4);
  endfunction

endpackage

### hdl/approximate_memory_fault_injector.sv
// Approximate memory fault injector: the top level.
// After reset a clearing pass zeroes every entry of the timestamp table, with
// in_ready low. The table is indexed by address bits above the word offset, so
// TABLE_DEPTH must be a power of two; the block does not check this. After a word
// is taken, a dispatch state picks the request. A store then takes one write step
// per slot; a load takes thirteen steps per slot (table read, a three-step 64x64
// saturating multiply built from three 32x32 partial products, eight generator
// steps one per cycle, table write); an arithmetic request takes ARITH and, on a
// hit, ARITH2. A DONE state then loads the output register once it is free. The
// generator is stepped only in the DRAW and arithmetic states. One item is in work
// at a time; the result sits in an output register while the next item is taken.
module approximate_memory_fault_injector #(
  parameter int unsigned TABLE_DEPTH = amfi_pkg::TableDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  amfi_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output amfi_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import amfi_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  state_t state, state_next;

  // configuration registers
  logic [63:0] decay_rate, mild_threshold, medium_threshold;
  logic [63:0] aggressive_threshold, test_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate <= '0;
      mild_threshold <= MildReset;
      medium_threshold <= MediumReset;
      aggressive_threshold <= AggressiveReset;
      test_threshold <= TestReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegDecay:      decay_rate <= cfg_data;
        RegMild:       mild_threshold <= cfg_data;
        RegMedium:     medium_threshold <= cfg_data;
        RegAggressive: aggressive_threshold <= cfg_data;
        RegTest:       test_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // working registers
  in_word_t    cur;
  logic [63:0] addr;
  logic [3:0]  slot_cnt;      // slots left
  logic [2:0]  slot_idx;      // slot number, picks the byte
  logic [2:0]  bit_idx;
  logic [63:0] result;
  logic [63:0] rng;
  logic [63:0] thr;
  logic [63:0] elapsed;
  logic [63:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [AW:0] clr_cnt;
  logic        out_valid_hold;

  logic [63:0] ram_rdata;
  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0] ram_wdata;

  amfi_ram #(.Width(64), .Depth(TABLE_DEPTH)) u_times (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [63:0] rng_step;
  assign rng_step = xs_step(rng);

  logic unaligned;
  assign unaligned = (cur.address & ({48'd0, cur.alignment} - 64'd1)) != 64'd0;

  logic [63:0] mode_thr;
  logic        mode_en;
  always_comb begin
    mode_thr = '0;
    mode_en = 1'b1;
    case (cur.error_mode)
      ModeMild:       mode_thr = mild_threshold;
      ModeMedium:     mode_thr = medium_threshold;
      ModeAggressive: mode_thr = aggressive_threshold;
      ModeTest:       mode_thr = test_threshold;
      default:        mode_en = 1'b0;
    endcase
  end

  // saturating product from partial products
  logic [64:0] mid_sum;
  logic [32:0] low_carry;
  logic        sat;
  assign mid_sum = {1'b0, pp_lh} + {1'b0, pp_hl};
  assign low_carry = {1'b0, pp_ll[63:32]} + {1'b0, mid_sum[31:0]};
  assign sat = (pp_hh != 64'd0) || (mid_sum[64:32] != 33'd0) || low_carry[32];

  assign in_ready = (state == ST_IDLE);
  assign out_valid = out_valid_hold;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (clr_cnt == (AW+1)'(TABLE_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:     if (in_valid && in_ready) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (cur.req_type == ReqArith) state_next = ST_ARITH;
        else if ((cur.req_type == ReqStore || cur.req_type == ReqLoad) && !unaligned
                 && slot_cnt != 4'd0) begin
          state_next = (cur.req_type == ReqLoad) ? ST_READ : ST_WRITE;
        end else state_next = ST_DONE;
      end
      ST_READ:  state_next = ST_MUL0;
      ST_MUL0:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_DRAW;
      ST_DRAW:  if (bit_idx == 3'd7) state_next = ST_WRITE;
      ST_WRITE: begin
        if (slot_cnt == 4'd1) state_next = ST_DONE;
        else state_next = (cur.req_type == ReqLoad) ? ST_READ : ST_WRITE;
      end
      ST_ARITH:  state_next = (mode_en && rng_step < mode_thr) ? ST_ARITH2 : ST_DONE;
      ST_ARITH2: state_next = ST_DONE;
      ST_DONE:   if (!out_valid_hold) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = addr[AW+1:2];
    ram_wdata = cur.timestamp;
    ram_raddr = addr[AW+1:2];
    if (state == ST_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_cnt[AW-1:0];
      ram_wdata = '0;
    end else if (state == ST_WRITE) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      rng <= SeedValue;
      out_valid_hold <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + (AW+1)'(1);
      if (out_valid_hold && out_ready) out_valid_hold <= 1'b0;
      case (state)
        ST_IDLE: if (in_valid && in_ready) begin
          cur <= in_data;
          addr <= in_data.address;
          slot_cnt <= (in_data.size_bytes > 4'd8) ? 4'd8 : in_data.size_bytes;
          slot_idx <= '0;
          result <= (in_data.req_type == ReqStore) ? 64'd0 : in_data.data_value;
        end
        ST_READ: ;
        ST_MUL0: begin
          elapsed <= cur.timestamp - ram_rdata;
        end
        ST_MUL1: begin
          pp_ll <= 64'(decay_rate[31:0]) * 64'(elapsed[31:0]);
          pp_lh <= 64'(decay_rate[31:0]) * 64'(elapsed[63:32]);
          pp_hl <= 64'(decay_rate[63:32]) * 64'(elapsed[31:0]);
          pp_hh <= ((decay_rate[63:32] != 32'd0) && (elapsed[63:32] != 32'd0)) ? 64'd1 : 64'd0;
        end
        ST_MUL2: begin
          thr <= sat ? '1 : (pp_ll + {mid_sum[31:0], 32'd0});
          bit_idx <= '0;
        end
        ST_DRAW: begin
          rng <= rng_step;
          if (rng_step < thr) result[{slot_idx, bit_idx}] <= ~result[{slot_idx, bit_idx}];
          bit_idx <= bit_idx + 3'd1;
        end
        ST_WRITE: begin
          addr <= addr + 64'd4;
          slot_cnt <= slot_cnt - 4'd1;
          slot_idx <= slot_idx + 3'd1;
        end
        ST_ARITH: rng <= rng_step;
        ST_ARITH2: begin
          rng <= rng_step;
          if (mode_en) result[7:0] <= rng_step[7:0];
        end
        ST_DONE: if (!out_valid_hold) begin
          out_valid_hold <= 1'b1;
          out_data.align_error <= (cur.req_type == ReqStore || cur.req_type == ReqLoad)
                                  && unaligned;
          out_data.result_value <= ((cur.req_type == ReqStore || cur.req_type == ReqLoad)
                                    && unaligned) || cur.req_type == ReqNone ? 64'd0 : result;
        end
        default: ;
      endcase
    end
  end
endmodule

### hdl/amfi_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module amfi_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### tb/approximate_memory_fault_injector_tb.sv
// Testbench for the approximate memory fault injector: predicted results, random traffic.
module approximate_memory_fault_injector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import amfi_pkg::*;

  localparam int unsigned Depth = TableDepthDefault;
  localparam int unsigned SlotBits = $clog2(Depth);
  localparam int unsigned CycleLimit = 4000000;

  // Predicts the injector and keeps the queue of pending results.
  class fault_scoreboard;
    logic [63:0] stamps [Depth];
    logic [63:0] rng;
    logic [63:0] regs [5];
    out_word_t pending [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned loads_flipped;
    int unsigned arith_hits;

    function new();
      foreach (stamps[i]) stamps[i] = '0;
      rng = SeedValue;
      regs[RegDecay] = '0;
      regs[RegMild] = MildReset;
      regs[RegMedium] = MediumReset;
      regs[RegAggressive] = AggressiveReset;
      regs[RegTest] = TestReset;
      mismatches = 0;
      results_seen = 0;
      loads_flipped = 0;
      arith_hits = 0;
    endfunction

    function logic [63:0] next_draw();
      logic [63:0] x;
      x = rng;
      x = x ^ (x >> 21);
      x = x ^ (x << 35);
      x = x ^ (x >> 4);
      rng = x;
      return x;
    endfunction

    function logic [63:0] decay_threshold(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      return (p[127:64] != 0) ? '1 : p[63:0];
    endfunction

    // note an accepted input word and queue its result
    function void note_input(in_word_t w);
      out_word_t r;
      logic [63:0] addr, thr;
      logic [SlotBits-1:0] s;
      int unsigned sz;
      logic hit;
      r = '0;
      addr = w.address;
      sz = (w.size_bytes > 8) ? 8 : w.size_bytes;
      if (w.req_type == ReqStore || w.req_type == ReqLoad) begin
        if ((addr & ({48'd0, w.alignment} - 64'd1)) != 0) begin
          r.align_error = 1'b1;
        end else if (w.req_type == ReqStore) begin
          for (int i = 0; i < sz; i++) begin
            stamps[addr[SlotBits+1:2]] = w.timestamp;
            addr = addr + 64'd4;
          end
        end else begin
          r.result_value = w.data_value;
          for (int i = 0; i < sz; i++) begin
            s = addr[SlotBits+1:2];
            thr = decay_threshold(regs[RegDecay], w.timestamp - stamps[s]);
            for (int j = 0; j < 8; j++)
              if (next_draw() < thr) r.result_value[i*8+j] = ~r.result_value[i*8+j];
            stamps[s] = w.timestamp;
            addr = addr + 64'd4;
          end
          if (r.result_value != w.data_value) loads_flipped++;
        end
      end else if (w.req_type == ReqArith) begin
        r.result_value = w.data_value;
        thr = next_draw();
        case (w.error_mode)
          ModeMild:       hit = thr < regs[RegMild];
          ModeMedium:     hit = thr < regs[RegMedium];
          ModeAggressive: hit = thr < regs[RegAggressive];
          ModeTest:       hit = thr < regs[RegTest];
          default:        hit = 1'b0;
        endcase
        if (hit) begin
          r.result_value[7:0] = next_draw() & 64'hFF;
          arith_hits++;
        end
      end
      pending.push_back(r);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(out_word_t got);
      out_word_t exp_w;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", got.result_value,
          got.align_error);
        return;
      end
      exp_w = pending.pop_front();
      if (got.result_value !== exp_w.result_value || got.align_error !== exp_w.align_error)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected value %h err %b, got value %h err %b",
            results_seen, exp_w.result_value, exp_w.align_error,
            got.result_value, got.align_error);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  fault_scoreboard board = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_off = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  logic [63:0] now_stamp = 64'd100;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  approximate_memory_fault_injector i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // output side: note accepted words, then choose next ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("approximate_memory_fault_injector_tb NOT OK");
      $finish;
    end
  end

  // one register write as a one-cycle enable pulse, then a wait with the enable low
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.regs[idx] = val;
    @(posedge clk);
  endtask

  // offer one word, hold it until accepted; valid stays up for a back-to-back word
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(w);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly well-formed accesses over a small address window
  function automatic in_word_t random_word();
    in_word_t w;
    int unsigned pick;
    logic [3:0] sizes [5] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd8};
    pick = $urandom_range(99);
    w.req_type = (pick < 35) ? ReqStore : (pick < 75) ? ReqLoad :
                 (pick < 97) ? ReqArith : ReqNone;
    w.size_bytes = ($urandom_range(19) == 0) ? 4'($urandom_range(15))
                                            : sizes[$urandom_range(4)];
    w.alignment = 16'(1 << $urandom_range(3));
    w.address = {$urandom_range(1) ? 50'd0 : 50'(rand64()), 8'($urandom_range(255)), 6'd0};
    if ($urandom_range(9) == 0) begin
      w.address = rand64();
      w.alignment = 16'($urandom);
    end
    w.address = w.address & ~(64'(w.alignment) - 64'd1) | (($urandom_range(7) == 0) ?
      64'($urandom_range(7)) : 64'd0);
    w.data_value = rand64();
    now_stamp = now_stamp + 64'($urandom_range(3000));
    w.timestamp = ($urandom_range(49) == 0) ? rand64() : now_stamp;
    w.error_mode = 3'($urandom_range(7));
    return w;
  endfunction

  function automatic in_word_t make_word(logic [1:0] req, logic [63:0] addr,
      logic [63:0] data, logic [15:0] algn, logic [63:0] ts, logic [3:0] sz, logic [2:0] md);
    in_word_t w;
    w.req_type = req; w.address = addr; w.data_value = data; w.alignment = algn;
    w.timestamp = ts; w.size_bytes = sz; w.error_mode = md;
    return w;
  endfunction

  task automatic random_phase(input int unsigned n, input int unsigned idle,
      input int unsigned stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_word(random_word());
    drain();
  endtask

  initial begin
    logic [63:0] rate_set [4] = '{64'd0, 64'h0000_0100_0000_0000, 64'h0010_0000_0000_0000, '1};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, all requests, unaligned, oversized, unknown
    write_reg(RegDecay, 64'h0000_1000_0000_0000);
    send_word(make_word(ReqStore, 64'd0, '1, 16'd8, 64'd10, 4'd8, 3'd0));
    send_word(make_word(ReqLoad, 64'd0, '1, 16'd8, 64'd5000, 4'd8, 3'd0));
    send_word(make_word(ReqLoad, 64'd0, '0, 16'd1, 64'd3, 4'd4, 3'd7));
    send_word(make_word(ReqStore, '1, '1, 16'hFFFF, '1, 4'hF, 3'd7));
    send_word(make_word(ReqLoad, 64'd3, '1, 16'd4, 64'd9, 4'd4, 3'd0));
    send_word(make_word(ReqLoad, 64'd4, '1, 16'd0, 64'd9, 4'd4, 3'd0));
    send_word(make_word(ReqLoad, 64'd0, 64'h5555, 16'd0, '1, 4'hF, 3'd0));
    send_word(make_word(ReqStore, 64'hFFFF_FFFF_FFFF_FFFC, 64'd0, 16'd4, 64'd1, 4'd8, 3'd0));
    send_word(make_word(ReqLoad, 64'hFFFF_FFFF_FFFF_FFFC, '1, 16'd4, '1, 4'd8, 3'd0));
    send_word(make_word(ReqLoad, 64'd64, 64'd0, 16'd1, 64'd7, 4'd0, 3'd0));
    send_word(make_word(ReqNone, '1, '1, 16'hFFFF, '1, 4'hF, 3'd7));
    for (int m = 0; m < 8; m++)
      send_word(make_word(ReqArith, 64'd1, '1, 16'hFFFF, 64'd0, 4'd0, 3'(m)));
    drain();

    // thresholds at extremes: every defined mode hits, then all thresholds are cleared
    write_reg(RegMild, '1); write_reg(RegMedium, '1);
    write_reg(RegAggressive, '1); write_reg(RegTest, '1);
    for (int m = 0; m < 8; m++)
      send_word(make_word(ReqArith, 64'd0, rand64(), 16'd0, 64'd0, 4'd0, 3'(m)));
    drain();
    write_reg(RegMild, '0); write_reg(RegMedium, '0);
    write_reg(RegAggressive, '0); write_reg(RegTest, '0);

    // random traffic over several register settings and idling profiles
    for (int k = 0; k < 4; k++) begin
      write_reg(RegDecay, rate_set[k]);
      write_reg(RegMild, rand64() >> $urandom_range(63));
      write_reg(RegMedium, rand64() >> $urandom_range(63));
      write_reg(RegAggressive, rand64() >> 1);
      write_reg(RegTest, rand64() >> $urandom_range(63));
      random_phase(80, 0, 0);
      random_phase(80, 57, 0);
      random_phase(80, 0, 57);
      random_phase(80, 12, 12);
    end

    // long receiver hold-off while offers continue
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 400;
    repeat (30) send_word(random_word());
    drain();
    random_phase(200, 0, 0);

    $display("covered %0d words: %0d results, %0d loads with flips, %0d arithmetic hits",
      items_sent, board.results_seen, board.loads_flipped, board.arith_hits);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("approximate_memory_fault_injector_tb OK");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("approximate_memory_fault_injector_tb NOT OK");
    end
    $finish;
  end
endmodule
